/* hw/rtl/encoder_velocity_median_estimator_defines.svh */
// ============================================================================
// encoder velocity median estimator assertion macros
// concurrent checks, compiled out for synthesis
// ============================================================================
`ifndef ENCODER_VELOCITY_MEDIAN_ESTIMATOR_DEFINES_SVH
`define ENCODER_VELOCITY_MEDIAN_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define EVME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evme assertion failed");

// antecedent implies consequent in the next cycle
`define EVME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evme assertion failed");

`else

`define EVME_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EVME_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/evme_pkg.sv */
// ============================================================================
// evme_pkg
// beat types, mode and register codes and fixed constants of the estimator
// ============================================================================
`default_nettype none

package evme_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_SIGN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 3'd4;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_REZERO = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    localparam logic        DIRECTION_RESET = 1'b0;
    localparam logic [15:0] RATE_RESET      = 16'd100;
    localparam logic [15:0] FLOOR_RESET     = 16'd4;
    localparam logic [7:0]  RATIO_RESET     = 8'd24;
    localparam logic [15:0] STOP_RESET      = 16'd14;

    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [39:0] VEL_MIN = 40'h80_0000_0000;
    localparam logic [39:0] VEL_MAX = 40'h7F_FFFF_FFFF;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int VEL_W_W = 58;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] total_counts;
        logic               link_up;
        logic               drive_active;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [39:0] velocity;
        logic               double_seen;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/evme_mul.sv */
// ============================================================================
// evme_mul
// shared signed multiplier with registered product
// ============================================================================
`default_nettype none

module evme_mul
    import evme_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hw/rtl/evme_ring.sv */
// ============================================================================
// evme_ring
// step magnitude ring with a rank test of one candidate entry per cycle
// ============================================================================
`default_nettype none

module evme_ring #(
    parameter int DEPTH = 9,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_slot,
    input  logic [31:0]      wr_value,
    input  logic [CNT_W-1:0] fill,
    input  logic [CNT_W-1:0] k,
    input  logic [IDX_W-1:0] cand,
    output logic [31:0]      cand_value,
    output logic             hit
);

    logic [31:0]      ring_mem [DEPTH];
    logic [CNT_W-1:0] less_cnt;
    logic [CNT_W-1:0] le_cnt;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_slot] <= wr_value;
        end
    end

    assign cand_value = ring_mem[cand];

    // count entries below and not above the candidate
    always_comb
    begin
        less_cnt = '0;
        le_cnt   = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (CNT_W'(j) < fill)
            begin
                if (ring_mem[j] < cand_value)
                begin
                    less_cnt = less_cnt + CNT_W'(1);
                end
                if (ring_mem[j] <= cand_value)
                begin
                    le_cnt = le_cnt + CNT_W'(1);
                end
            end
        end
    end

    assign hit = (less_cnt <= k) && (k < le_cnt);

endmodule

`default_nettype wire

/* hw/rtl/encoder_velocity_median_estimator.sv */
// ============================================================================
// encoder velocity median estimator
// start, re-zero, idle and no-step ticks go from accept through PREP to DONE, which registers the result
// a tick with a step adds RANK (once the ring holds data), RATIO, VEL and SAT before DONE
// one beat at a time: the rank loop tests one candidate per cycle, sample_ready is high only in IDLE
// reset: async active low, registers to defaults, zero pending, ring empty
// ============================================================================
`default_nettype none
`include "encoder_velocity_median_estimator_defines.svh"

module encoder_velocity_median_estimator
    import evme_pkg::*;
#(
    parameter int RING_DEPTH = 9
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_RANK  = 7'b0000100,
        S_RATIO = 7'b0001000,
        S_VEL   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic               dir_reg, dir_next;
    logic [15:0]        rate_reg, rate_next;
    logic [15:0]        floor_reg, floor_next;
    logic [7:0]         ratio_reg, ratio_next;
    logic [15:0]        stop_reg, stop_next;
    logic [31:0]        offset_reg, offset_next;
    logic [31:0]        prev_reg, prev_next;
    logic               pending_reg, pending_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [39:0] vel_reg, vel_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   cand_reg, cand_next;
    logic               dbl_reg, dbl_next;
    logic               result_valid_reg, result_valid_next;

    sample_t            samp_reg, samp_next;
    logic [31:0]        med_reg, med_next;
    logic [31:0]        step_reg, step_next;
    logic [31:0]        mag_reg, mag_next;
    result_t            result_reg, result_next;

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                ring_wr_en;
    logic [31:0]         ring_wr_value;
    logic [31:0]         ring_value;
    logic                ring_hit;
    logic                rank_last;
    logic [CNT_W-1:0]    rank_k;

    logic [31:0]         counts;
    logic [31:0]         off_eff;
    logic [31:0]         prev_eff;
    logic [31:0]         pos_diff;
    logic [31:0]         pos_calc;
    logic [31:0]         step_calc;
    logic [31:0]         mag_calc;
    logic                dbl_calc;
    logic signed [VEL_W_W-1:0] vel_wide;
    logic signed [VEL_W_W-1:0] vel_scaled;
    logic signed [VEL_W_W-1:0] vel_signed;
    logic [VEL_W_W-40:0]       vel_hi;
    logic [39:0]         vel_sat;
    logic signed [39:0]  vel_round;
    logic signed [39:0]  vel_half;
    logic [39:0]         vel_abs;
    logic [39:0]         stop_level;
    logic [39:0]         vel_decay;

    evme_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    evme_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk        (clk),
        .wr_en      (ring_wr_en),
        .wr_slot    (slot_reg),
        .wr_value   (ring_wr_value),
        .fill       (fill_reg),
        .k          (rank_k),
        .cand       (cand_reg),
        .cand_value (ring_value),
        .hit        (ring_hit)
    );

    assign rank_k    = fill_reg >> 1;
    assign rank_last = (CNT_W'(cand_reg) + CNT_W'(1)) >= fill_reg;

    // position and step from the held sample
    assign counts    = samp_reg.total_counts;
    assign off_eff   = pending_reg ? counts : offset_reg;
    assign prev_eff  = pending_reg ? counts : prev_reg;
    assign pos_diff  = counts - off_eff;
    assign pos_calc  = !dir_reg ? pos_diff :
                       ((pos_diff == POS_MIN) ? POS_MAX : (32'd0 - pos_diff));
    assign step_calc = counts - prev_eff;
    assign mag_calc  = step_calc[31] ? (32'd0 - step_calc) : step_calc;

    // double test against the registered ratio times median
    assign dbl_calc = (mag_reg >= {16'd0, floor_reg}) && (med_reg != 32'd0) &&
                      ({4'd0, mag_reg, 4'd0} > mul_p[39:0]);

    // step velocity scaling and saturation
    assign vel_wide   = {{(VEL_W_W - MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
    assign vel_scaled = dbl_reg ? (vel_wide <<< 7) : (vel_wide <<< 8);
    assign vel_signed = dir_reg ? -vel_scaled : vel_scaled;
    assign vel_hi     = vel_signed[VEL_W_W-1:39];
    assign vel_sat    = ((vel_hi == '0) || (vel_hi == '1)) ? vel_signed[39:0] :
                        (vel_signed[VEL_W_W-1] ? VEL_MIN : VEL_MAX);

    // decay toward zero
    assign vel_round  = vel_reg + $signed({39'd0, vel_reg[39]});
    assign vel_half   = vel_round >>> 1;
    assign vel_abs    = vel_half[39] ? (40'd0 - vel_half) : vel_half;
    assign stop_level = {16'd0, stop_reg, 8'd0};
    assign vel_decay  = (vel_abs < stop_level) ? 40'd0 : vel_half;

    assign ring_wr_value = dbl_reg ? {1'b0, mag_reg[31:1]} : mag_reg;

    assign sample_ready = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        dir_next          = dir_reg;
        rate_next         = rate_reg;
        floor_next        = floor_reg;
        ratio_next        = ratio_reg;
        stop_next         = stop_reg;
        offset_next       = offset_reg;
        prev_next         = prev_reg;
        pending_next      = pending_reg;
        pos_next          = pos_reg;
        vel_next          = vel_reg;
        fill_next         = fill_reg;
        slot_next         = slot_reg;
        cand_next         = cand_reg;
        dbl_next          = dbl_reg;
        result_valid_next = result_valid_reg;
        samp_next         = samp_reg;
        med_next          = med_reg;
        step_next         = step_reg;
        mag_next          = mag_reg;
        result_next       = result_reg;
        mul_en            = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        ring_wr_en        = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIRECTION_SIGN: dir_next   = cfg_data[0];
                CFG_SAMPLE_RATE:    rate_next  = cfg_data;
                CFG_DOUBLE_FLOOR:   floor_next = cfg_data;
                CFG_DOUBLE_RATIO:   ratio_next = cfg_data[7:0];
                CFG_STOP_THRESHOLD: stop_next  = cfg_data;
                default:            ;
            endcase
        end

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    samp_next  = sample;
                    cand_next  = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                dbl_next   = 1'b0;
                state_next = S_DONE;
                case (samp_reg.mode)
                    MODE_START:
                    begin
                        pending_next = 1'b1;
                        offset_next  = counts;
                        pos_next     = '0;
                        vel_next     = '0;
                        prev_next    = '0;
                        fill_next    = '0;
                        slot_next    = '0;
                    end
                    MODE_REZERO:
                    begin
                        offset_next = counts;
                        pos_next    = '0;
                    end
                    MODE_TICK:
                    begin
                        if (samp_reg.link_up)
                        begin
                            offset_next  = off_eff;
                            prev_next    = counts;
                            pending_next = 1'b0;
                            pos_next     = pos_calc;
                            step_next    = step_calc;
                            mag_next     = mag_calc;
                            if (step_calc != 32'd0)
                            begin
                                if (fill_reg == '0)
                                begin
                                    med_next   = '0;
                                    state_next = S_RATIO;
                                end
                                else
                                begin
                                    state_next = S_RANK;
                                end
                            end
                            else if (!samp_reg.drive_active)
                            begin
                                vel_next = vel_decay;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_RANK:
            begin
                if (ring_hit || rank_last)
                begin
                    med_next   = ring_value;
                    state_next = S_RATIO;
                end
                else
                begin
                    cand_next = cand_reg + IDX_W'(1);
                end
            end
            S_RATIO:
            begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, med_reg};
                mul_b      = {9'd0, ratio_reg};
                state_next = S_VEL;
            end
            S_VEL:
            begin
                dbl_next   = dbl_calc;
                mul_en     = 1'b1;
                mul_a      = {step_reg[31], step_reg};
                mul_b      = {1'b0, rate_reg};
                state_next = S_SAT;
            end
            S_SAT:
            begin
                vel_next   = vel_sat;
                ring_wr_en = 1'b1;
                slot_next  = (slot_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
                if (fill_reg < CNT_W'(RING_DEPTH))
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.position    = pos_reg;
                    result_next.velocity    = vel_reg;
                    result_next.double_seen = dbl_reg;
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            dir_reg          <= DIRECTION_RESET;
            rate_reg         <= RATE_RESET;
            floor_reg        <= FLOOR_RESET;
            ratio_reg        <= RATIO_RESET;
            stop_reg         <= STOP_RESET;
            offset_reg       <= '0;
            prev_reg         <= '0;
            pending_reg      <= 1'b1;
            pos_reg          <= '0;
            vel_reg          <= '0;
            fill_reg         <= '0;
            slot_reg         <= '0;
            cand_reg         <= '0;
            dbl_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dir_reg          <= dir_next;
            rate_reg         <= rate_next;
            floor_reg        <= floor_next;
            ratio_reg        <= ratio_next;
            stop_reg         <= stop_next;
            offset_reg       <= offset_next;
            prev_reg         <= prev_next;
            pending_reg      <= pending_next;
            pos_reg          <= pos_next;
            vel_reg          <= vel_next;
            fill_reg         <= fill_next;
            slot_reg         <= slot_next;
            cand_reg         <= cand_next;
            dbl_reg          <= dbl_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg   <= samp_next;
        med_reg    <= med_next;
        step_reg   <= step_next;
        mag_reg    <= mag_next;
        result_reg <= result_next;
    end

    `EVME_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_W'(RING_DEPTH))
    `EVME_ASSERT_IMP(a_slot_bound, clk, rst_n, 1'b1, slot_reg <= IDX_W'(RING_DEPTH - 1))
    `EVME_ASSERT_IMP(a_rank_nonempty, clk, rst_n, state_reg == S_RANK, fill_reg != '0)
    `EVME_ASSERT_IMP(a_rank_found, clk, rst_n, (state_reg == S_RANK) && rank_last, ring_hit)
    `EVME_ASSERT_NXT(a_accept_prep, clk, rst_n, sample_valid && sample_ready, state_reg == S_PREP)

endmodule

`default_nettype wire
